// ===== rtl/nnis_pkg.sv =====
// Shared types and constants for the nearest-neighbor image scaler.
package nnis_pkg;

  // Frame store geometry and dimension limits.
  localparam int FRAME_PIXELS = 65536;
  localparam int ADDR_W       = 16;
  localparam int DIM_W        = 11;
  localparam int CNT_W        = 10;
  localparam int FRAC_BITS    = 16;
  localparam int STEP_W       = 27;
  localparam int ACC_W        = 32;
  localparam int PIX_W        = 32;
  localparam int BPP_W        = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;

  // Item actions.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BPP        = 3'd4;

  // Input word: a load of one source pixel or a request for the next output pixel.
  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel_value;
  } in_word_t;

  // Output word: one destination pixel.
  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             frame_last;
  } out_word_t;

endpackage

// ===== rtl/nnis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module nnis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/nearest_neighbor_image_scaler_unit.sv =====
// Nearest-neighbor image scaler: frame store, 16.16 stepping and a shared sequencer.
// A load word passes through S_LOAD; a read word passes through S_MUL, S_ADDR and S_RDATA
// to its result register, waiting in S_RDATA while that register is full. The first read
// of an output frame first goes through S_DIV: two restoring divisions on one shared divider
// give the x and y steps, one quotient bit per cycle. New words wait for S_IDLE. Synchronous
// active-low reset clears control, counters, steps and out_valid and presets the sizes and
// pixel size; the frame store is not cleared and holds undefined data until written.
module nearest_neighbor_image_scaler_unit
  import nnis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ADDR  = 3'd4;
  localparam logic [2:0] S_RDATA = 3'd5;

  localparam logic [4:0] DIV_LAST_BIT = 5'(STEP_W - 1);
  localparam int         PROD_W       = ACC_W - FRAC_BITS + DIM_W;

  // Clamp a written dimension into 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    begin
      r = v;
      if (v == '0) begin
        r = 11'd1;
      end else if (v > MAX_DIM) begin
        r = MAX_DIM;
      end
      return r;
    end
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] load_addr_r, load_addr_nxt;
  logic [STEP_W-1:0] x_step_r, x_step_nxt, y_step_r, y_step_nxt;
  logic [ACC_W-1:0]  x_acc_r, x_acc_nxt, y_acc_r, y_acc_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [DIM_W-1:0]  src_w_r, src_w_nxt, src_h_r, src_h_nxt;
  logic [DIM_W-1:0]  dst_w_r, dst_w_nxt, dst_h_r, dst_h_nxt;
  logic [BPP_W-1:0]  bpp_r, bpp_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;
  logic              div_sel_r, div_sel_nxt;
  logic [4:0]        div_cnt_r, div_cnt_nxt;
  logic [DIM_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] quo_r, quo_nxt;
  logic [ADDR_W-1:0] prod_r, prod_nxt;
  logic              last_r, last_nxt;

  logic              in_acc;
  logic              cfg_acc;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;

  // Shared multiplier: source area for loads, row base address for reads.
  logic [ACC_W-FRAC_BITS-1:0] mul_a;
  logic [PROD_W-1:0]          mul_p;

  // Shared restoring divider datapath, one quotient bit per cycle.
  logic [DIM_W-1:0] div_divisor;
  logic [DIM_W:0]   div_trial;
  logic [DIM_W:0]   div_diff;
  logic             div_ge;
  logic [DIM_W-1:0] div_rem_step;
  logic [STEP_W-1:0] div_quo_step;

  // Load address and row/column stepping helpers.
  logic [ADDR_W:0]   load_inc;
  logic [DIM_W-1:0]  col_inc, row_inc;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ram_we    = in_acc && (in_data.action == ACT_LOAD);
  assign ram_re    = (state_r == S_ADDR);
  assign ram_raddr = prod_r + x_acc_r[ACC_W-1:FRAC_BITS];

  assign mul_a = (state_r == S_LOAD) ? {{(ACC_W-FRAC_BITS-DIM_W){1'b0}}, src_h_r}
                                     : y_acc_r[ACC_W-1:FRAC_BITS];
  assign mul_p = mul_a * src_w_r;

  assign div_divisor  = div_sel_r ? dst_h_r : dst_w_r;
  assign div_trial    = {rem_r, quo_r[STEP_W-1]};
  assign div_diff     = div_trial - {1'b0, div_divisor};
  assign div_ge       = (div_trial >= {1'b0, div_divisor});
  assign div_rem_step = div_ge ? div_diff[DIM_W-1:0] : div_trial[DIM_W-1:0];
  assign div_quo_step = {quo_r[STEP_W-2:0], div_ge};

  assign load_inc = {1'b0, load_addr_r} + 17'd1;
  assign col_inc  = {1'b0, col_r} + 11'd1;
  assign row_inc  = {1'b0, row_r} + 11'd1;

  // Frame store.
  nnis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_PIXELS)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_addr_r),
    .wdata (in_data.pixel_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration writes, with dimensions clamped on the way in.
  always_comb begin
    src_w_nxt = src_w_r;
    src_h_nxt = src_h_r;
    dst_w_nxt = dst_w_r;
    dst_h_nxt = dst_h_r;
    bpp_nxt   = bpp_r;
    if (cfg_acc) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_w_nxt = clamp_dim(cfg_wdata[DIM_W-1:0]);
        REG_SRC_HEIGHT: src_h_nxt = clamp_dim(cfg_wdata[DIM_W-1:0]);
        REG_DST_WIDTH:  dst_w_nxt = clamp_dim(cfg_wdata[DIM_W-1:0]);
        REG_DST_HEIGHT: dst_h_nxt = clamp_dim(cfg_wdata[DIM_W-1:0]);
        REG_BPP:        bpp_nxt   = cfg_wdata[BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt     = state_r;
    load_addr_nxt = load_addr_r;
    x_step_nxt    = x_step_r;
    y_step_nxt    = y_step_r;
    x_acc_nxt     = x_acc_r;
    y_acc_nxt     = y_acc_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_sel_nxt   = div_sel_r;
    div_cnt_nxt   = div_cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    prod_nxt      = prod_r;
    last_nxt      = last_r;

    // The result register empties when the consumer takes the word.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.action == ACT_LOAD) begin
            state_nxt = S_LOAD;
          end else if (col_r == '0 && row_r == '0) begin
            // Frame start: clear the accumulators and divide for the x step first.
            x_acc_nxt   = '0;
            y_acc_nxt   = '0;
            div_sel_nxt = 1'b0;
            div_cnt_nxt = DIV_LAST_BIT;
            rem_nxt     = '0;
            quo_nxt     = {src_w_r, {FRAC_BITS{1'b0}}};
            state_nxt   = S_DIV;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end

      S_LOAD: begin
        // Wrap after the source area or the store size, whichever comes first.
        if ({{(PROD_W-ADDR_W-1){1'b0}}, load_inc} >= mul_p || load_inc[ADDR_W]) begin
          load_addr_nxt = '0;
        end else begin
          load_addr_nxt = load_inc[ADDR_W-1:0];
        end
        state_nxt = S_IDLE;
      end

      S_DIV: begin
        rem_nxt     = div_rem_step;
        quo_nxt     = div_quo_step;
        div_cnt_nxt = div_cnt_r - 5'd1;
        if (div_cnt_r == '0) begin
          if (!div_sel_r) begin
            x_step_nxt  = div_quo_step;
            div_sel_nxt = 1'b1;
            div_cnt_nxt = DIV_LAST_BIT;
            rem_nxt     = '0;
            quo_nxt     = {src_h_r, {FRAC_BITS{1'b0}}};
          end else begin
            y_step_nxt = div_quo_step;
            state_nxt  = S_MUL;
          end
        end
      end

      S_MUL: begin
        prod_nxt  = mul_p[ADDR_W-1:0];
        state_nxt = S_ADDR;
      end

      S_ADDR: begin
        // The read is issued this cycle; step the position for the next word.
        last_nxt  = 1'b0;
        col_nxt   = col_inc[CNT_W-1:0];
        x_acc_nxt = x_acc_r + {{(ACC_W-STEP_W){1'b0}}, x_step_r};
        if (col_inc >= dst_w_r) begin
          col_nxt   = '0;
          x_acc_nxt = '0;
          row_nxt   = row_inc[CNT_W-1:0];
          y_acc_nxt = y_acc_r + {{(ACC_W-STEP_W){1'b0}}, y_step_r};
          if (row_inc >= dst_h_r) begin
            row_nxt   = '0;
            y_acc_nxt = '0;
            last_nxt  = 1'b1;
          end
        end
        state_nxt = S_RDATA;
      end

      S_RDATA: begin
        // Wait here until the result register is free.
        if (!out_valid_r || out_ready) begin
          out_data_nxt.out_pixel  = (bpp_r == 3'd3) ? {8'h00, ram_rdata[PIX_W-9:0]}
                                                    : ram_rdata;
          out_data_nxt.frame_last = last_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, counters, steps and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_addr_r <= '0;
      x_step_r    <= '0;
      y_step_r    <= '0;
      x_acc_r     <= '0;
      y_acc_r     <= '0;
      col_r       <= '0;
      row_r       <= '0;
      src_w_r     <= 11'd1;
      src_h_r     <= 11'd1;
      dst_w_r     <= 11'd1;
      dst_h_r     <= 11'd1;
      bpp_r       <= 3'd4;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_addr_r <= load_addr_nxt;
      x_step_r    <= x_step_nxt;
      y_step_r    <= y_step_nxt;
      x_acc_r     <= x_acc_nxt;
      y_acc_r     <= y_acc_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      src_w_r     <= src_w_nxt;
      src_h_r     <= src_h_nxt;
      dst_w_r     <= dst_w_nxt;
      dst_h_r     <= dst_h_nxt;
      bpp_r       <= bpp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, set before they are used.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    div_sel_r  <= div_sel_nxt;
    div_cnt_r  <= div_cnt_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    prod_r     <= prod_nxt;
    last_r     <= last_nxt;
  end

endmodule

// ===== tb/nearest_neighbor_image_scaler_checker.sv =====
`timescale 1ns / 100ps
// Scaler checker: follows all three channels, predicts each output word and compares.
module nearest_neighbor_image_scaler_checker
  import nnis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_word_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_count
);

  localparam logic [BPP_W-1:0] BPP_24 = 3'd3;
  localparam logic [BPP_W-1:0] BPP_32 = 3'd4;
  localparam int REPORT_LIMIT = 50;

  // Shadow of the scaler: source frame, load pointer, steps, accumulators, counters.
  logic [PIX_W-1:0]  src_frame [FRAME_PIXELS];
  int unsigned       load_slot;
  logic [STEP_W-1:0] x_step, y_step;
  logic [ACC_W-1:0]  x_acc, y_acc;
  int unsigned       out_col, out_row;
  int unsigned       src_w, src_h, dst_w, dst_h;
  logic [BPP_W-1:0]  pix_bytes;
  out_word_t         owed_pixels [$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  // A written size of zero counts as one; anything above the maximum is held there.
  function automatic int unsigned bound_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  always @(posedge clk) begin : track
    out_word_t        want;
    logic [ACC_W-1:0] src_addr;
    int unsigned      span;

    if (!rst_n) begin
      load_slot = 0;
      x_step    = '0;
      y_step    = '0;
      x_acc     = '0;
      y_acc     = '0;
      out_col   = 0;
      out_row   = 0;
      src_w     = 1;
      src_h     = 1;
      dst_w     = 1;
      dst_h     = 1;
      pix_bytes = BPP_32;
      owed_pixels.delete();
    end else begin
      // Register writes are for the user to make only while the block is idle; the block does not enforce it.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_w = bound_dim(cfg_wdata[DIM_W-1:0]);
          REG_SRC_HEIGHT: src_h = bound_dim(cfg_wdata[DIM_W-1:0]);
          REG_DST_WIDTH:  dst_w = bound_dim(cfg_wdata[DIM_W-1:0]);
          REG_DST_HEIGHT: dst_h = bound_dim(cfg_wdata[DIM_W-1:0]);
          REG_BPP:        pix_bytes = cfg_wdata[BPP_W-1:0];
          default: ;
        endcase
      end

      // Compare a delivered pixel against the oldest prediction.
      if (out_valid && out_ready) begin
        if (owed_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $error("unexpected output word: out_pixel %h, frame_last %b",
                   out_data.out_pixel, out_data.frame_last);
        end else begin
          want = owed_pixels.pop_front();
          if (out_data.out_pixel !== want.out_pixel) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $error("out_pixel: expected %h, got %h", want.out_pixel, out_data.out_pixel);
          end
          if (out_data.frame_last !== want.frame_last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $error("frame_last: expected %b, got %b", want.frame_last, out_data.frame_last);
          end
        end
      end

      if (in_valid && in_ready) begin
        if (in_data.action == ACT_LOAD) begin
          // Loads fill the frame in raster order and wrap at the frame area.
          span = src_w * src_h;
          if (span > FRAME_PIXELS) span = FRAME_PIXELS;
          load_slot = load_slot % FRAME_PIXELS;
          src_frame[load_slot] = in_data.pixel_value;
          load_slot++;
          if (load_slot >= span) load_slot = 0;
        end else begin
          // New output frame: fresh 11.16 steps from the current sizes.
          if (out_col == 0 && out_row == 0) begin
            x_step = STEP_W'((src_w << FRAC_BITS) / dst_w);
            y_step = STEP_W'((src_h << FRAC_BITS) / dst_h);
            x_acc  = '0;
            y_acc  = '0;
          end
          want     = '0;
          src_addr = (y_acc >> FRAC_BITS) * src_w + (x_acc >> FRAC_BITS);
          want.out_pixel = src_frame[src_addr[ADDR_W-1:0]];
          if (pix_bytes == BPP_24) want.out_pixel[PIX_W-1:PIX_W-8] = '0;

          // Advance the column, then the row; a shrunk size ends the row or frame early.
          out_col++;
          x_acc += x_step;
          if (out_col >= dst_w) begin
            out_col = 0;
            x_acc   = '0;
            out_row++;
            y_acc  += y_step;
            if (out_row >= dst_h) begin
              out_row = 0;
              y_acc   = '0;
              want.frame_last = 1'b1;
            end
          end
          owed_pixels.push_back(want);
        end
      end
    end
    pending_count <= owed_pixels.size();
  end

endmodule

// ===== tb/nearest_neighbor_image_scaler_unit_test.sv =====
`timescale 1ns / 100ps
// Scaler testbench top: clock, reset, stimulus phases and the final verdict.
module nearest_neighbor_image_scaler_unit_test;
  import nnis_pkg::*;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count;
  int                    pending_count;

  // Idling rates in percent, changed per phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Sizes as the block sees them, and which frame slots hold loaded pixels.
  int unsigned src_w_now = 1, src_h_now = 1, dst_w_now = 1, dst_h_now = 1;
  int unsigned fill_ptr = 0;
  bit          stored [FRAME_PIXELS];
  int          unstored = 0;

  nearest_neighbor_image_scaler_unit dut (.*);

  nearest_neighbor_image_scaler_checker pixel_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("** nearest_neighbor_image_scaler_unit: FAILED **");
    $finish;
  end

  // The receiver stalls at random at the current rate.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic int unsigned bound_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned load_limit();
    int unsigned span;
    span = src_w_now * src_h_now;
    return (span > FRAME_PIXELS) ? FRAME_PIXELS : span;
  endfunction

  // Present one word, idling first at the current rate, and wait for its acceptance.
  task automatic push_word(input in_word_t w);
    int unsigned slot;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (w.action == ACT_LOAD) begin
      slot = fill_ptr % FRAME_PIXELS;
      if (!stored[slot]) begin
        stored[slot] = 1'b1;
        if (slot < load_limit()) unstored--;
      end
      fill_ptr = slot + 1;
      if (fill_ptr >= load_limit()) fill_ptr = 0;
    end
  endtask

  task automatic load_pixel(input logic [PIX_W-1:0] p);
    in_word_t w;
    w.action      = ACT_LOAD;
    w.pixel_value = p;
    push_word(w);
  endtask

  // The pixel field of a read word is ignored, so it carries noise.
  task automatic read_pixel();
    in_word_t w;
    w.action      = ACT_READ;
    w.pixel_value = $urandom;
    push_word(w);
  endtask

  // Stop sending, wait for every predicted pixel, then let in-flight loads finish.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (8) @(posedge clk);
  endtask

  // Register write with random junk above the register's width.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    if (idx == REG_BPP) word[BPP_W-1:0] = val[BPP_W-1:0];
    else word[DIM_W-1:0] = val[DIM_W-1:0];
    case (idx)
      REG_SRC_WIDTH:  src_w_now = bound_dim(val[DIM_W-1:0]);
      REG_SRC_HEIGHT: src_h_now = bound_dim(val[DIM_W-1:0]);
      REG_DST_WIDTH:  dst_w_now = bound_dim(val[DIM_W-1:0]);
      REG_DST_HEIGHT: dst_h_now = bound_dim(val[DIM_W-1:0]);
      default: ;
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned sw, sh, dw, dh, bpp_sel, burst_len, pick;
    int unsigned burst_words;

    burst_words = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Small upscale with 24-bit pixels: extreme pixel values, a load wrap, a whole frame.
    write_reg(REG_SRC_WIDTH, 2);
    write_reg(REG_SRC_HEIGHT, 2);
    write_reg(REG_DST_WIDTH, 3);
    write_reg(REG_DST_HEIGHT, 3);
    write_reg(REG_BPP, 3);
    load_pixel(32'h0000_0000);
    load_pixel(32'hFFFF_FFFF);
    load_pixel(32'h8000_0001);
    load_pixel(32'h7FFF_FFFE);
    repeat (9) read_pixel();
    settle();

    // Out-of-range sizes clamp and an odd pixel size acts as 32 bits.
    write_reg(REG_BPP, 7);
    write_reg(REG_DST_WIDTH, 0);
    write_reg(REG_DST_HEIGHT, 2000);
    repeat (3) read_pixel();
    settle();

    // Shrinking the height mid-frame ends the frame on the next pixel.
    write_reg(REG_DST_HEIGHT, 1);
    write_reg(REG_BPP, 0);
    read_pixel();
    read_pixel();

    // Random rounds: each picks sizes, refills the frame and runs a mixed burst.
    for (int round = 0; burst_words < 1800; round++) begin
      case (round % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase

      // Close the frame under way by shrinking it to one pixel and reading once.
      settle();
      write_reg(REG_DST_WIDTH, 1);
      write_reg(REG_DST_HEIGHT, 1);
      read_pixel();
      settle();

      sw = $urandom_range(16, 1);
      sh = $urandom_range(16, 1);
      dw = $urandom_range(12, 1);
      dh = $urandom_range(10, 1);
      bpp_sel = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(4, 3);
      case (round)
        // Widest source (written out of range, height written as zero) and destination.
        1: begin sw = 2000; sh = 0; dw = 1024; dh = 1; end
        // Tallest source and destination.
        2: begin sw = 1; sh = 1024; dw = 1; dh = 1024; bpp_sel = 3; end
        // Strong upscale of a square source across the widest destination.
        4: begin sw = 32; sh = 32; dw = 1024; dh = $urandom_range(8, 1); end
        default: ;
      endcase
      write_reg(REG_SRC_WIDTH, sw);
      write_reg(REG_SRC_HEIGHT, sh);
      write_reg(REG_DST_WIDTH, dw);
      write_reg(REG_DST_HEIGHT, dh);
      write_reg(REG_BPP, bpp_sel);

      // Load until every slot the new sizes can reach holds a pixel.
      unstored = 0;
      for (int a = 0; a < load_limit(); a++) if (!stored[a]) unstored++;
      while (unstored > 0) begin
        load_pixel($urandom);
        burst_words++;
      end

      burst_len = $urandom_range(120, 40);
      repeat (burst_len) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          // Shrink the destination or change the pixel size with the frame under way.
          settle();
          case ($urandom_range(2))
            0: write_reg(REG_DST_WIDTH, $urandom_range(dst_w_now, 1));
            1: write_reg(REG_DST_HEIGHT, $urandom_range(dst_h_now, 1));
            default: write_reg(REG_BPP, $urandom_range(7));
          endcase
        end else if (pick < 30) begin
          load_pixel($urandom);
        end else begin
          read_pixel();
        end
        burst_words++;
      end
    end

    settle();
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("** nearest_neighbor_image_scaler_unit: PASSED **");
    end else begin
      $display("** nearest_neighbor_image_scaler_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/nnis_pkg.sv
rtl/nnis_ram.sv
rtl/nearest_neighbor_image_scaler_unit.sv
tb/nearest_neighbor_image_scaler_checker.sv
tb/nearest_neighbor_image_scaler_unit_test.sv
